>>> hw/rtl/bfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

  // fixed field and register widths
  localparam int PIX_W       = 8;
  localparam int SCALE_W     = 4;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_W     = 12;

  // block sums: 255 * 15 * 15 fits in 16 bits
  localparam int SUM_W       = 16;

  // reciprocal of s*s scaled by 2**24, rounded up; exact for sums below 2**16
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;
    logic             image_done;
  } result_t;

  // per-channel partial or column sums
  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum3_t;

  // request flags from the front to the back
  typedef struct packed {
    logic first_row;   // first row of the block: overwrite the column sum
    logic emit;        // last row of the block: produce an output pixel
    logic last_block;  // final output pixel of the image
  } bfd_flags_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACC,
    BK_MUL,
    BK_PUSH
  } bfd_bk_state_t;

  // ceil(2**24 / (s*s)); zero scale never reaches here
  function automatic logic [RECIP_W-1:0] recip_lut(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    begin
      case (s)
        4'd1:    r = 25'd16777216;
        4'd2:    r = 25'd4194304;
        4'd3:    r = 25'd1864136;
        4'd4:    r = 25'd1048576;
        4'd5:    r = 25'd671089;
        4'd6:    r = 25'd466034;
        4'd7:    r = 25'd342393;
        4'd8:    r = 25'd262144;
        4'd9:    r = 25'd207127;
        4'd10:   r = 25'd167773;
        4'd11:   r = 25'd138655;
        4'd12:   r = 25'd116509;
        4'd13:   r = 25'd99274;
        4'd14:   r = 25'd85599;
        4'd15:   r = 25'd74566;
        default: r = 25'd16777216;
      endcase
      return r;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bfd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module bfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  // depth is a power of two so the pointers wrap on their own
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = store[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bfd_front import bfd_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                push,
  input  pixel_t              pixel,
  input  logic [SCALE_W-1:0]  scale,
  input  logic [COORD_W-1:0]  image_width,
  input  logic [COORD_W-1:0]  image_height,
  input  logic                cmd_full,
  output logic                cmd_push,
  output logic [$clog2(MAX_WIDTH)+$bits(bfd_flags_t)+$bits(sum3_t)-1:0] cmd_data
);

  localparam int IDX_W = $clog2(MAX_WIDTH);
  localparam int SUB_W = $clog2(MAX_SCALE);
  localparam int EXT_W = COORD_W + 1;

  logic [COORD_W-1:0] pix_col;
  logic [COORD_W-1:0] pix_row;
  logic [COORD_W-1:0] col_base;
  logic [COORD_W-1:0] row_base;
  logic [SUB_W-1:0]   sub_col;
  logic [SUB_W-1:0]   sub_row;
  logic [IDX_W-1:0]   blk_col;
  sum3_t              partial;

  logic               accept;
  logic [EXT_W-1:0]   s_ext;
  logic [EXT_W-1:0]   col_end;
  logic [EXT_W-1:0]   row_end;
  logic               col_fit;
  logic               row_fit;
  logic               col_final;
  logic               row_final;
  logic               in_block;
  logic               col_last;
  logic               row_last;
  logic               line_end;
  logic               image_end;
  sum3_t              partial_next;
  bfd_flags_t         flags;

  assign accept = push && !cmd_full;

  // where the pixel sits relative to complete blocks
  always_comb begin
    s_ext     = EXT_W'(scale);
    col_end   = EXT_W'(col_base) + s_ext;
    row_end   = EXT_W'(row_base) + s_ext;
    col_fit   = col_end <= EXT_W'(image_width);
    row_fit   = row_end <= EXT_W'(image_height);
    col_final = (col_end + s_ext) > EXT_W'(image_width);
    row_final = (row_end + s_ext) > EXT_W'(image_height);
    in_block  = col_fit && row_fit;
    col_last  = (5'(sub_col) + 5'd1) == 5'(scale);
    row_last  = (5'(sub_row) + 5'd1) == 5'(scale);
    line_end  = (EXT_W'(pix_col) + 1'b1) >= EXT_W'(image_width);
    image_end = (EXT_W'(pix_row) + 1'b1) >= EXT_W'(image_height);
  end

  // running row sum of the current block
  always_comb begin
    partial_next.red   = partial.red   + SUM_W'(pixel.pixel_red);
    partial_next.green = partial.green + SUM_W'(pixel.pixel_green);
    partial_next.blue  = partial.blue  + SUM_W'(pixel.pixel_blue);
  end

  // request to the back at the end of each block row segment
  always_comb begin
    flags.first_row  = (sub_row == '0);
    flags.emit       = row_last;
    flags.last_block = row_last && col_final && row_final;
    cmd_push         = accept && in_block && col_last;
    cmd_data         = {blk_col, flags, partial_next};
  end

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pix_col  <= '0;
      pix_row  <= '0;
      col_base <= '0;
      row_base <= '0;
      sub_col  <= '0;
      sub_row  <= '0;
      blk_col  <= '0;
      partial  <= '0;
    end else if (accept) begin
      if (line_end) begin
        partial <= '0;
      end else if (in_block) begin
        partial <= col_last ? '0 : partial_next;
      end
      if (line_end) begin
        pix_col  <= '0;
        col_base <= '0;
        sub_col  <= '0;
        blk_col  <= '0;
        if (image_end) begin
          pix_row  <= '0;
          row_base <= '0;
          sub_row  <= '0;
        end else begin
          pix_row <= pix_row + 1'b1;
          if (row_last) begin
            sub_row  <= '0;
            row_base <= row_base + COORD_W'(scale);
          end else begin
            sub_row <= sub_row + 1'b1;
          end
        end
      end else begin
        pix_col <= pix_col + 1'b1;
        if (col_last) begin
          sub_col  <= '0;
          col_base <= col_base + COORD_W'(scale);
          blk_col  <= blk_col + 1'b1;
        end else begin
          sub_col <= sub_col + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/bfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bfd_back import bfd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  logic [$clog2(MAX_WIDTH)+$bits(bfd_flags_t)+$bits(sum3_t)-1:0] cmd_data,
  output logic                cmd_pop,
  input  logic [RECIP_W-1:0]  recip,
  input  logic                out_full,
  output logic                out_push,
  output result_t             out_data
);

  localparam int IDX_W  = $clog2(MAX_WIDTH);
  localparam int PROD_W = SUM_W + RECIP_W;

  // column sums for one block row
  sum3_t              col_sums [MAX_WIDTH];

  bfd_bk_state_t      state;
  bfd_bk_state_t      state_next;

  logic [IDX_W-1:0]   head_idx;
  bfd_flags_t         head_flags;
  sum3_t              head_part;

  logic [IDX_W-1:0]   cur_idx;
  bfd_flags_t         cur_flags;
  sum3_t              cur_part;
  sum3_t              rd_sum;
  sum3_t              acc;
  sum3_t              acc_next;
  logic [PROD_W-1:0]  prod_red;
  logic [PROD_W-1:0]  prod_green;
  logic [PROD_W-1:0]  prod_blue;

  assign {head_idx, head_flags, head_part} = cmd_data;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // sequencer: read, accumulate and write back, scale, deliver
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    out_push   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          state_next = BK_ACC;
        end
      end
      BK_ACC: begin
        state_next = cur_flags.emit ? BK_MUL : BK_IDLE;
      end
      BK_MUL: begin
        state_next = BK_PUSH;
      end
      BK_PUSH: begin
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // new column sum
  always_comb begin
    if (cur_flags.first_row) begin
      acc_next = cur_part;
    end else begin
      acc_next.red   = rd_sum.red   + cur_part.red;
      acc_next.green = rd_sum.green + cur_part.green;
      acc_next.blue  = rd_sum.blue  + cur_part.blue;
    end
  end

  // request capture, memory access and reciprocal multiply
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_idx   <= head_idx;
      cur_flags <= head_flags;
      cur_part  <= head_part;
      rd_sum    <= col_sums[head_idx];
    end
    if (state == BK_ACC) begin
      col_sums[cur_idx] <= acc_next;
      acc               <= acc_next;
    end
    if (state == BK_MUL) begin
      prod_red   <= PROD_W'(acc.red)   * PROD_W'(recip);
      prod_green <= PROD_W'(acc.green) * PROD_W'(recip);
      prod_blue  <= PROD_W'(acc.blue)  * PROD_W'(recip);
    end
  end

  // truncated averages
  always_comb begin
    out_data.avg_red    = prod_red[RECIP_SHIFT +: PIX_W];
    out_data.avg_green  = prod_green[RECIP_SHIFT +: PIX_W];
    out_data.avg_blue   = prod_blue[RECIP_SHIFT +: PIX_W];
    out_data.image_done = cur_flags.last_block;
  end

endmodule

`default_nettype wire

>>> hw/rtl/box_filter_downscale_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Box filter downscaler: takes RGB pixels in raster order and emits, in raster
// order of the smaller image, the truncated per-channel average of every
// complete scale-by-scale block; trailing columns and rows that do not fill a
// block are taken and dropped, and image_done marks the last output pixel.
// The front accepts one pixel per clock while its 4-entry request queue has
// room and sends one request per finished block row segment (every scale
// pixels). The back owns the single-port column-sum memory; per request it reads,
// adds and writes back, and on the last row of a block also multiplies by a
// reciprocal of scale squared and then delivers into a 2-entry result queue,
// waiting while that queue is full. The sustained rate is one pixel per clock
// for scale 4 and up while the result queue has room; smaller scales slow the
// intake on the last row of each block row. A write to any register index
// restarts the image; write the registers only while no results are pending.

module box_filter_downscale_core import bfd_pkg::*; #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  pixel_t               pixel,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  localparam int IDX_W     = $clog2(MAX_WIDTH);
  localparam int CMD_W     = IDX_W + $bits(bfd_flags_t) + $bits(sum3_t);
  localparam int RES_W     = $bits(result_t);
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  localparam int S_CAP_I   = (MAX_SCALE > 15) ? 15 : MAX_SCALE;
  localparam int W_CAP_I   = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam int W_RST_I   = (640 > W_CAP_I) ? W_CAP_I : 640;

  localparam logic [SCALE_W-1:0] S_CAP = SCALE_W'(S_CAP_I);
  localparam logic [CFG_W-1:0]   W_CAP = CFG_W'(W_CAP_I);
  localparam logic [CFG_W-1:0]   W_RST = CFG_W'(W_RST_I);

  logic [SCALE_W-1:0] scale;
  logic [COORD_W-1:0] image_width;
  logic [COORD_W-1:0] image_height;
  logic [RECIP_W-1:0] recip;

  logic [SCALE_W-1:0] scale_eff;
  logic [COORD_W-1:0] width_eff;
  logic [COORD_W-1:0] height_eff;

  logic               cmd_push;
  logic [CMD_W-1:0]   cmd_wdata;
  logic               cmd_full;
  logic               cmd_pop;
  logic [CMD_W-1:0]   cmd_rdata;
  logic               cmd_empty;

  logic               res_push;
  result_t            res_wdata;
  logic               res_full;
  logic [RES_W-1:0]   res_rdata;

  // clamp written values to the supported range
  always_comb begin
    scale_eff = wr_data[SCALE_W-1:0];
    if (scale_eff == '0)        scale_eff = SCALE_W'(1);
    else if (scale_eff > S_CAP) scale_eff = S_CAP;

    width_eff = wr_data;
    if (width_eff == '0)        width_eff = COORD_W'(1);
    else if (width_eff > W_CAP) width_eff = W_CAP;

    height_eff = wr_data;
    if (height_eff == '0)       height_eff = COORD_W'(1);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= SCALE_W'(2);
      image_width  <= W_RST;
      image_height <= COORD_W'(480);
      recip        <= recip_lut(SCALE_W'(2));
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCALE: begin
          scale <= scale_eff;
          recip <= recip_lut(scale_eff);
        end
        REG_WIDTH:  image_width  <= width_eff;
        REG_HEIGHT: image_height <= height_eff;
        default: begin
        end
      endcase
    end
  end

  // pixel intake and block classification
  bfd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .restart      (wr_en),
    .push         (push),
    .pixel        (pixel),
    .scale        (scale),
    .image_width  (image_width),
    .image_height (image_height),
    .cmd_full     (cmd_full),
    .cmd_push     (cmd_push),
    .cmd_data     (cmd_wdata)
  );

  assign full = cmd_full;

  // request queue between front and back
  bfd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (cmd_wdata),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rdata),
    .empty   (cmd_empty)
  );

  // column sums and averaging
  bfd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .cmd_pop   (cmd_pop),
    .recip     (recip),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_data  (res_wdata)
  );

  // result queue toward the consumer
  bfd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wdata),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rdata),
    .empty   (empty)
  );

  assign result = result_t'(res_rdata);

  // internal queue discipline
  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("request pushed into a full queue");

  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("back took a request from an empty queue");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_res_after_pop: assert property (@(posedge clk) disable iff (rst)
    res_push |=> !empty)
    else $error("delivered result missing from the result queue");

endmodule

`default_nettype wire
